>>> design/tsc_pkg.sv
// Shared constants, datapath widths, the pipeline item type and the
// reciprocal tables of the Taylor sine/cosine unit. No dependencies.
package tsc_pkg;

  localparam int FRAC_BITS        = 29;
  localparam int ANGLE_W          = 32;
  localparam int OUT_W            = 32;
  localparam int SERIES_TERMS_DEF = 10;

  // x^2 stays at or below 16.0, every term magnitude below 16.0
  localparam int X2_W    = FRAC_BITS + 5;
  localparam int MAG_W   = FRAC_BITS + 5;
  localparam int Q_W     = FRAC_BITS + 10;
  localparam int RECIP_W = FRAC_BITS;
  localparam int SUM_W   = FRAC_BITS + 9;

  // operand splits for the partial products
  localparam int LO_SPLIT = MAG_W / 2;
  localparam int Q_SPLIT  = (Q_W + 1) / 2;

  localparam logic [MAG_W-1:0] MAG_ONE = MAG_W'(64'd1 << FRAC_BITS);
  localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(64'd1 << (FRAC_BITS + 4));
  localparam logic [X2_W-1:0]  X2_MAX  = X2_W'(64'd1 << (FRAC_BITS + 4));

  typedef struct packed {
    logic                    vld;
    logic [X2_W-1:0]         x2;
    logic                    sin_neg;
    logic [MAG_W-1:0]        cos_mag;
    logic [MAG_W-1:0]        sin_mag;
    logic signed [SUM_W-1:0] cos_sum;
    logic signed [SUM_W-1:0] sin_sum;
  } tsc_item_t;

  // round(2^29 / ((2i-1)(2i)))
  function automatic logic [RECIP_W-1:0] tsc_cos_recip(input int unsigned term);
    logic [RECIP_W-1:0] r;
    case (term)
      1:       r = RECIP_W'(268435456);
      2:       r = RECIP_W'(44739243);
      3:       r = RECIP_W'(17895697);
      4:       r = RECIP_W'(9586981);
      5:       r = RECIP_W'(5965232);
      6:       r = RECIP_W'(4067204);
      7:       r = RECIP_W'(2949840);
      8:       r = RECIP_W'(2236962);
      9:       r = RECIP_W'(1754480);
      10:      r = RECIP_W'(1412818);
      11:      r = RECIP_W'(1162058);
      12:      r = RECIP_W'(972592);
      13:      r = RECIP_W'(825955);
      14:      r = RECIP_W'(710147);
      15:      r = RECIP_W'(617093);
      default: r = '0;
    endcase
    return r;
  endfunction

  // round(2^29 / ((2i)(2i+1)))
  function automatic logic [RECIP_W-1:0] tsc_sin_recip(input int unsigned term);
    logic [RECIP_W-1:0] r;
    case (term)
      1:       r = RECIP_W'(89478485);
      2:       r = RECIP_W'(26843546);
      3:       r = RECIP_W'(12782641);
      4:       r = RECIP_W'(7456540);
      5:       r = RECIP_W'(4880645);
      6:       r = RECIP_W'(3441480);
      7:       r = RECIP_W'(2556528);
      8:       r = RECIP_W'(1973790);
      9:       r = RECIP_W'(1569798);
      10:      r = RECIP_W'(1278264);
      11:      r = RECIP_W'(1061010);
      12:      r = RECIP_W'(894785);
      13:      r = RECIP_W'(764773);
      14:      r = RECIP_W'(661171);
      15:      r = RECIP_W'(577281);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/taylor_sine_cosine_unit.sv
// Pipeline from input transfer to result: two stages for x^2, four per series step,
// one output stage.
// Throughput: one angle per cycle; the whole pipeline holds while a result is stalled.
// Reset: synchronous, clears the valid bits; payload is not reset.
// Top level of the Taylor sine/cosine unit; depends on tsc_pkg, tsc_square
// and tsc_term.
module taylor_sine_cosine_unit import tsc_pkg::*; #(
  parameter int SERIES_TERMS = SERIES_TERMS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ANGLE_W-1:0] in_angle,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   out_sine_value,
  output logic signed [OUT_W-1:0]   out_cosine_value
);

  localparam bit LAST_ODD = ((SERIES_TERMS - 1) % 2) == 1;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    $signed({{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_LO =
    $signed({{(SUM_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}});

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_HI) begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (v < SAT_LO) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  tsc_item_t chain [SERIES_TERMS];

  logic                    en;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] sine_r;
  logic signed [OUT_W-1:0] cosine_r;
  logic signed [SUM_W-1:0] cmag_s;
  logic signed [SUM_W-1:0] smag_s;
  logic signed [SUM_W-1:0] cos_fin;
  logic signed [SUM_W-1:0] sin_fin;
  logic                    sterm_neg;

  // every stage moves unless a finished result is held at the output
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  tsc_square u_square (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .angle  (in_angle),
    .item   (chain[0])
  );

  for (genvar k = 1; k < SERIES_TERMS; k++) begin : g_term
    tsc_term #(.TERM(k)) u_term (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .item_in  (chain[k-1]),
      .item_out (chain[k])
    );
  end

  // fold in the last pending term, then clamp to the output format
  assign cmag_s    = $signed(SUM_W'(chain[SERIES_TERMS-1].cos_mag));
  assign smag_s    = $signed(SUM_W'(chain[SERIES_TERMS-1].sin_mag));
  assign sterm_neg = chain[SERIES_TERMS-1].sin_neg ^ LAST_ODD;
  assign cos_fin   = LAST_ODD ? (chain[SERIES_TERMS-1].cos_sum - cmag_s)
                              : (chain[SERIES_TERMS-1].cos_sum + cmag_s);
  assign sin_fin   = sterm_neg ? (chain[SERIES_TERMS-1].sin_sum - smag_s)
                               : (chain[SERIES_TERMS-1].sin_sum + smag_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[SERIES_TERMS-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine_r   <= sat_out(sin_fin);
      cosine_r <= sat_out(cos_fin);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sine_value   = sine_r;
  assign out_cosine_value = cosine_r;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

>>> design/tsc_square.sv
// Front end of the series pipeline: angle magnitude, x^2 with rounding,
// and the seed terms. Two register stages. Depends on tsc_pkg.
module tsc_square import tsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic signed [ANGLE_W-1:0] angle,
  output tsc_item_t                 item
);

  localparam int P_W = 2 * ANGLE_W;

  logic [ANGLE_W-1:0] ax;
  logic [P_W-1:0]     prod_nxt;
  logic [P_W-1:0]     rnd;
  logic [X2_W-1:0]    x2_nxt;

  logic               vld1_r;
  logic               neg1_r;
  logic [ANGLE_W-1:0] ax1_r;
  logic [P_W-1:0]     prod1_r;
  logic               vld2_r;
  logic               neg2_r;
  logic [ANGLE_W-1:0] ax2_r;
  logic [X2_W-1:0]    x2_r;

  assign ax       = angle[ANGLE_W-1] ? (~angle + 1'b1) : angle;
  assign prod_nxt = P_W'(ax) * P_W'(ax);
  assign rnd      = prod1_r + (P_W'(1) << (FRAC_BITS - 1));
  assign x2_nxt   = rnd[FRAC_BITS+X2_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r  <= angle[ANGLE_W-1];
      ax1_r   <= ax;
      prod1_r <= prod_nxt;
      neg2_r  <= neg1_r;
      ax2_r   <= ax1_r;
      x2_r    <= x2_nxt;
    end
  end

  // cosine seeds with 1.0, sine with x; both sums start empty
  assign item = '{vld: vld2_r, x2: x2_r, sin_neg: neg2_r,
                  cos_mag: MAG_ONE, sin_mag: MAG_W'(ax2_r),
                  cos_sum: '0, sin_sum: '0};

  a_x2_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r |-> (x2_r <= X2_MAX))
    else $error("x squared above 16.0");

endmodule

>>> design/tsc_term.sv
// One series step for cosine and sine side by side: accumulate the pending
// term, multiply by x^2, then by the step reciprocal. Four register stages.
// Depends on tsc_pkg.
module tsc_term import tsc_pkg::*; #(
  parameter int TERM = 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  tsc_item_t item_in,
  output tsc_item_t item_out
);

  localparam logic [RECIP_W-1:0] COS_R = tsc_cos_recip(TERM);
  localparam logic [RECIP_W-1:0] SIN_R = tsc_sin_recip(TERM);
  // sign of the pending term, index TERM-1
  localparam bit PREV_ODD = ((TERM - 1) % 2) == 1;

  localparam int PP_W = LO_SPLIT + X2_W;
  localparam int PQ_W = PP_W + LO_SPLIT;
  localparam int PR_W = Q_SPLIT + RECIP_W;
  localparam int PT_W = PR_W + Q_SPLIT;

  // stage a: accumulate and first partial products
  logic signed [SUM_W-1:0] cmag_s;
  logic signed [SUM_W-1:0] smag_s;
  logic signed [SUM_W-1:0] csum_nxt;
  logic signed [SUM_W-1:0] ssum_nxt;
  logic                    sterm_neg;

  logic                    a_vld_r;
  logic [X2_W-1:0]         a_x2_r;
  logic                    a_sneg_r;
  logic signed [SUM_W-1:0] a_csum_r;
  logic signed [SUM_W-1:0] a_ssum_r;
  logic [PP_W-1:0]         a_cpl_r;
  logic [PP_W-1:0]         a_cph_r;
  logic [PP_W-1:0]         a_spl_r;
  logic [PP_W-1:0]         a_sph_r;

  // stage b: rounded product with x^2
  logic [PQ_W-1:0]         cq_full;
  logic [PQ_W-1:0]         sq_full;

  logic                    b_vld_r;
  logic [X2_W-1:0]         b_x2_r;
  logic                    b_sneg_r;
  logic signed [SUM_W-1:0] b_csum_r;
  logic signed [SUM_W-1:0] b_ssum_r;
  logic [Q_W-1:0]          b_cq_r;
  logic [Q_W-1:0]          b_sq_r;

  // stage c: partial products with the reciprocal
  logic                    c_vld_r;
  logic [X2_W-1:0]         c_x2_r;
  logic                    c_sneg_r;
  logic signed [SUM_W-1:0] c_csum_r;
  logic signed [SUM_W-1:0] c_ssum_r;
  logic [PR_W-1:0]         c_cpc_r;
  logic [PR_W-1:0]         c_cpd_r;
  logic [PR_W-1:0]         c_spc_r;
  logic [PR_W-1:0]         c_spd_r;

  // stage d: rounded new term magnitudes
  logic [PT_W-1:0]         ct_full;
  logic [PT_W-1:0]         st_full;

  logic                    d_vld_r;
  logic [X2_W-1:0]         d_x2_r;
  logic                    d_sneg_r;
  logic signed [SUM_W-1:0] d_csum_r;
  logic signed [SUM_W-1:0] d_ssum_r;
  logic [MAG_W-1:0]        d_cmag_r;
  logic [MAG_W-1:0]        d_smag_r;

  assign cmag_s    = $signed(SUM_W'(item_in.cos_mag));
  assign smag_s    = $signed(SUM_W'(item_in.sin_mag));
  assign sterm_neg = item_in.sin_neg ^ PREV_ODD;
  assign csum_nxt  = PREV_ODD ? (item_in.cos_sum - cmag_s) : (item_in.cos_sum + cmag_s);
  assign ssum_nxt  = sterm_neg ? (item_in.sin_sum - smag_s) : (item_in.sin_sum + smag_s);

  assign cq_full = PQ_W'(a_cpl_r) + (PQ_W'(a_cph_r) << LO_SPLIT)
                 + (PQ_W'(1) << (FRAC_BITS - 1));
  assign sq_full = PQ_W'(a_spl_r) + (PQ_W'(a_sph_r) << LO_SPLIT)
                 + (PQ_W'(1) << (FRAC_BITS - 1));

  assign ct_full = PT_W'(c_cpc_r) + (PT_W'(c_cpd_r) << Q_SPLIT)
                 + (PT_W'(1) << (FRAC_BITS - 1));
  assign st_full = PT_W'(c_spc_r) + (PT_W'(c_spd_r) << Q_SPLIT)
                 + (PT_W'(1) << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= item_in.vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x2_r   <= item_in.x2;
      a_sneg_r <= item_in.sin_neg;
      a_csum_r <= csum_nxt;
      a_ssum_r <= ssum_nxt;
      a_cpl_r  <= PP_W'(item_in.cos_mag[LO_SPLIT-1:0]) * PP_W'(item_in.x2);
      a_cph_r  <= PP_W'(item_in.cos_mag[MAG_W-1:LO_SPLIT]) * PP_W'(item_in.x2);
      a_spl_r  <= PP_W'(item_in.sin_mag[LO_SPLIT-1:0]) * PP_W'(item_in.x2);
      a_sph_r  <= PP_W'(item_in.sin_mag[MAG_W-1:LO_SPLIT]) * PP_W'(item_in.x2);

      b_x2_r   <= a_x2_r;
      b_sneg_r <= a_sneg_r;
      b_csum_r <= a_csum_r;
      b_ssum_r <= a_ssum_r;
      b_cq_r   <= cq_full[FRAC_BITS+Q_W-1:FRAC_BITS];
      b_sq_r   <= sq_full[FRAC_BITS+Q_W-1:FRAC_BITS];

      c_x2_r   <= b_x2_r;
      c_sneg_r <= b_sneg_r;
      c_csum_r <= b_csum_r;
      c_ssum_r <= b_ssum_r;
      c_cpc_r  <= PR_W'(b_cq_r[Q_SPLIT-1:0]) * PR_W'(COS_R);
      c_cpd_r  <= PR_W'(b_cq_r[Q_W-1:Q_SPLIT]) * PR_W'(COS_R);
      c_spc_r  <= PR_W'(b_sq_r[Q_SPLIT-1:0]) * PR_W'(SIN_R);
      c_spd_r  <= PR_W'(b_sq_r[Q_W-1:Q_SPLIT]) * PR_W'(SIN_R);

      d_x2_r   <= c_x2_r;
      d_sneg_r <= c_sneg_r;
      d_csum_r <= c_csum_r;
      d_ssum_r <= c_ssum_r;
      d_cmag_r <= ct_full[FRAC_BITS+MAG_W-1:FRAC_BITS];
      d_smag_r <= st_full[FRAC_BITS+MAG_W-1:FRAC_BITS];
    end
  end

  assign item_out = '{vld: d_vld_r, x2: d_x2_r, sin_neg: d_sneg_r,
                      cos_mag: d_cmag_r, sin_mag: d_smag_r,
                      cos_sum: d_csum_r, sin_sum: d_ssum_r};

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({a_vld_r, b_vld_r, c_vld_r, d_vld_r}))
    else $error("stage valid moved while stalled");

  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r |-> ((d_cmag_r <= MAG_MAX) && (d_smag_r <= MAG_MAX)))
    else $error("term magnitude above 16.0");

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Testbench for taylor_sine_cosine_unit: directed angles, then random ones, checked
// against a bit-exact series predictor. Depends on tsc_pkg and the unit's RTL.
module tb;
  import tsc_pkg::*;

  localparam int TERMS = SERIES_TERMS_DEF;
  localparam int LATENCY = 4 * TERMS - 1;
  localparam int N_DIRECTED = 21;
  localparam int N_RANDOM = 1800;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [31:0] ONE_Q = 32'sd536870912;

  typedef struct packed {
    logic [ANGLE_W-1:0]        angle;
    logic signed [OUT_W-1:0]   sine;
    logic signed [OUT_W-1:0]   cosine;
  } sincos_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               known;
    logic [OUT_W-1:0]   sine;
    logic [OUT_W-1:0]   cosine;
  } angle_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_RHYTHM, STALL_HEAVY} stall_mode_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [ANGLE_W-1:0] in_angle = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [OUT_W-1:0]   out_sine_value;
  logic signed [OUT_W-1:0]   out_cosine_value;

  sincos_t     pending_sincos[$];
  int          err_count = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_phase = 0;

  taylor_sine_cosine_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_angle         (in_angle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sine_value   (out_sine_value),
    .out_cosine_value (out_cosine_value)
  );

  always #4 clk = ~clk;

  // fixed-point product, rounded half away from zero, saturated to +/-(2^63-1)
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic         neg;
    logic [63:0]  ma, mb;
    logic [127:0] prod, res;
    neg = (a < 0) != (b < 0);
    ma = a[63] ? (~a + 64'd1) : a;
    mb = b[63] ? (~b + 64'd1) : b;
    prod = {64'd0, ma} * {64'd0, mb};
    res = (prod + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (res > {64'd0, S64_MAX}) res = {64'd0, S64_MAX};
    return neg ? -$signed(res[63:0]) : $signed(res[63:0]);
  endfunction

  function automatic logic signed [63:0] sum_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > $signed({1'b0, S64_MAX})) return S64_MAX;
    if (s < -$signed({1'b0, S64_MAX}) - 65'sd1) return -S64_MAX - 64'sd1;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] term_recip(input logic [63:0] d);
    return ((64'd1 << FRAC_BITS) + d / 2) / d;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[OUT_W-1:0];
  endfunction

  function automatic sincos_t sincos_series(input logic [ANGLE_W-1:0] ang);
    logic signed [63:0] x, x2, cos_term, cos_sum, sin_term, sin_sum;
    logic [63:0]        k;
    sincos_t            r;
    x = {{(64-ANGLE_W){ang[ANGLE_W-1]}}, ang};
    x2 = fx_mul(x, x);
    cos_term = 64'sd1 <<< FRAC_BITS;
    cos_sum = cos_term;
    sin_term = x;
    sin_sum = x;
    for (int i = 1; i < TERMS; i++) begin
      k = 64'(i);
      cos_term = -fx_mul(fx_mul(cos_term, x2), term_recip((2 * k - 1) * (2 * k)));
      cos_sum = sum_sat(cos_sum, cos_term);
      sin_term = -fx_mul(fx_mul(sin_term, x2), term_recip((2 * k) * (2 * k + 1)));
      sin_sum = sum_sat(sin_sum, sin_term);
    end
    r.angle = ang;
    r.sine = clamp_out(sin_sum);
    r.cosine = clamp_out(cos_sum);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    err_count++;
  endtask

  // sender: bursts of random length, random gaps between them
  task automatic send_angle(input logic [ANGLE_W-1:0] ang, input sincos_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_angle <= $urandom;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_angle <= ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_sincos.push_back(want);
  endtask

  // receiver stall pattern; the mode is redrawn whenever its phase counter runs out
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        stall_phase <= $urandom_range(20, 300);
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_SPARSE: out_stall <= ($urandom_range(0, 99) < 30);
        STALL_RHYTHM: out_stall <= ((stall_phase % 5) < 3);
        default:      out_stall <= ($urandom_range(0, 99) < 85);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    sincos_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sincos.size() == 0) begin
        report_mismatch($sformatf("unexpected result sine=%h cosine=%h",
                                  out_sine_value, out_cosine_value));
      end else begin
        want = pending_sincos.pop_front();
        if (out_sine_value !== want.sine)
          report_mismatch($sformatf("angle %h sine %h, want %h",
                                    want.angle, out_sine_value, want.sine));
        if (out_cosine_value !== want.cosine)
          report_mismatch($sformatf("angle %h cosine %h, want %h",
                                    want.angle, out_cosine_value, want.cosine));
      end
    end
  end

  initial begin : stimulus
    angle_row_t         rows [N_DIRECTED];
    sincos_t            want;
    logic [ANGLE_W-1:0] ang;
    int                 waited;
    // x2 rounds to zero for a one-lsb angle, so the series collapses to x and 1.0
    rows = '{
      '{32'h0000_0000, 1'b1, 32'h0000_0000, ONE_Q},
      '{32'h0000_0001, 1'b1, 32'h0000_0001, ONE_Q},
      '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ONE_Q},
      '{32'h2000_0000, 1'b0, '0, '0},
      '{32'hE000_0000, 1'b0, '0, '0},
      '{32'd843314857, 1'b0, '0, '0},
      '{-32'sd843314857, 1'b0, '0, '0},
      '{32'd1686629713, 1'b0, '0, '0},
      '{-32'sd1686629713, 1'b0, '0, '0},
      '{32'h4000_0000, 1'b0, '0, '0},
      '{32'hC000_0000, 1'b0, '0, '0},
      '{32'h6000_0000, 1'b0, '0, '0},
      '{32'hA000_0000, 1'b0, '0, '0},
      '{32'h7FFF_FFFF, 1'b0, '0, '0},
      '{32'h8000_0000, 1'b0, '0, '0},
      '{32'h5555_5555, 1'b0, '0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0, '0},
      '{32'h0000_FFFF, 1'b0, '0, '0},
      '{32'h0000_4000, 1'b0, '0, '0},   // x squared lands exactly on a rounding tie
      '{32'hFFFF_C000, 1'b0, '0, '0},
      '{32'h7FFF_0000, 1'b0, '0, '0}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].known) begin
        want.angle = rows[i].angle;
        want.sine = rows[i].sine;
        want.cosine = rows[i].cosine;
      end else begin
        want = sincos_series(rows[i].angle);
      end
      send_angle(rows[i].angle, want);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 3))
        0, 1: ang = $urandom;
        2: ang = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        default: ang = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 1 << 20)
                                            : 32'h8000_0000 + $urandom_range(0, 1 << 20);
      endcase
      send_angle(ang, sincos_series(ang));
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_sincos.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (pending_sincos.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_sincos.size()));

    if (err_count == 0) begin
      $display("[taylor_sine_cosine_unit] OK");
    end else begin
      $display("[taylor_sine_cosine_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[taylor_sine_cosine_unit] ERROR");
    $finish;
  end

endmodule
